// ===== rtl/rvt_pkg.sv =====
package rvt_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int KEY_WIDTH   = 32;
  localparam int VALUE_WIDTH = 8;
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int NW = CW + 1;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_ASSIGN = 1'b1;

  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic                   operation;
    logic [KEY_WIDTH-1:0]   range_start;
    logic [KEY_WIDTH-1:0]   range_end;
    logic [VALUE_WIDTH-1:0] new_value;
    logic [KEY_WIDTH-1:0]   lookup_key;
  } in_req_t;

  typedef struct packed {
    logic [7:0] read_value;
    logic [1:0] status;
  } out_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_SCAN_DRAIN,
    S_CALC,
    S_SHIFT,
    S_SHIFT_DRAIN,
    S_INS1,
    S_INS2,
    S_DONE
  } state_t;

  typedef struct packed {
    logic       load;
    logic       scan;
    logic       calc;
    logic       shift;
    logic       ins1;
    logic       ins2;
    logic       commit;
    logic       out_set;
    logic [1:0] out_status;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic no_move;
    logic lookup;
    logic scan_last;
    logic move_last;
    logic out_busy;
  } sts_t;

endpackage

// ===== rtl/rvt_ctrl.sv =====
module rvt_ctrl (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  rvt_pkg::sts_t sts,
  output rvt_pkg::cmd_t cmd
);

  rvt_pkg::state_t state_r, state_nxt;
  logic [1:0] status_r, status_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= rvt_pkg::S_IDLE;
      status_r <= rvt_pkg::STATUS_DONE;
    end else begin
      state_r  <= state_nxt;
      status_r <= status_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    status_nxt     = status_r;
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.out_status = status_r;
    case (state_r)
      rvt_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = rvt_pkg::S_SCAN;
        end
      end
      rvt_pkg::S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) state_nxt = rvt_pkg::S_SCAN_DRAIN;
      end
      rvt_pkg::S_SCAN_DRAIN: state_nxt = rvt_pkg::S_CALC;
      rvt_pkg::S_CALC: begin
        cmd.calc   = 1'b1;
        status_nxt = rvt_pkg::STATUS_DONE;
        if (sts.lookup) begin
          state_nxt = rvt_pkg::S_DONE;
        end else if (sts.empty) begin
          status_nxt = rvt_pkg::STATUS_EMPTY;
          state_nxt  = rvt_pkg::S_DONE;
        end else if (sts.full) begin
          status_nxt = rvt_pkg::STATUS_FULL;
          state_nxt  = rvt_pkg::S_DONE;
        end else if (sts.no_move) begin
          state_nxt = rvt_pkg::S_INS1;
        end else begin
          state_nxt = rvt_pkg::S_SHIFT;
        end
      end
      rvt_pkg::S_SHIFT: begin
        cmd.shift = 1'b1;
        if (sts.move_last) state_nxt = rvt_pkg::S_SHIFT_DRAIN;
      end
      rvt_pkg::S_SHIFT_DRAIN: state_nxt = rvt_pkg::S_INS1;
      rvt_pkg::S_INS1: begin
        cmd.ins1  = 1'b1;
        state_nxt = rvt_pkg::S_INS2;
      end
      rvt_pkg::S_INS2: begin
        cmd.ins2   = 1'b1;
        cmd.commit = 1'b1;
        state_nxt  = rvt_pkg::S_DONE;
      end
      rvt_pkg::S_DONE: begin
        if (!sts.out_busy) begin
          cmd.out_set = 1'b1;
          state_nxt   = rvt_pkg::S_IDLE;
        end
      end
      default: state_nxt = rvt_pkg::S_IDLE;
    endcase
  end

endmodule

// ===== rtl/rvt_datapath.sv =====
module rvt_datapath (
  input  logic             clk,
  input  logic             rst_n,
  input  rvt_pkg::in_req_t in_req,
  input  logic             cfg_we,
  input  logic [7:0]       cfg_data,
  input  rvt_pkg::cmd_t    cmd,
  output rvt_pkg::sts_t    sts,
  output logic             out_valid,
  input  logic             out_ready,
  output rvt_pkg::out_rsp_t out_rsp
);

  localparam int AW = rvt_pkg::AW;
  localparam int CW = rvt_pkg::CW;
  localparam int NW = rvt_pkg::NW;
  localparam int KW = rvt_pkg::KEY_WIDTH;
  localparam int VW = rvt_pkg::VALUE_WIDTH;

  logic [KW-1:0] key_mem [rvt_pkg::TABLE_DEPTH];
  logic [VW-1:0] val_mem [rvt_pkg::TABLE_DEPTH];

  rvt_pkg::in_req_t req_r;
  logic [CW-1:0] cnt_r, idx_r, sj_r, p_r, q_r, mleft_r, n_r;
  logic [VW-1:0] vp_r, vq_r, res_r, default_r;
  logic          e0_valid_r, sv_r, mv_v_r, up_r, ins1_r, ins2_r;
  logic [AW-1:0] mv_dst_r, off_r;
  logic [KW-1:0] rd_key_r;
  logic [VW-1:0] rd_val_r;
  logic          rd_zero_r;
  logic          out_valid_r;
  rvt_pkg::out_rsp_t out_r;

  logic [KW-1:0] rk;
  logic [VW-1:0] rv;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [KW-1:0] wr_key;
  logic [VW-1:0] wr_val;
  logic          ins1_c, ins2_c;
  logic [NW-1:0] dst_c, n_c;

  // entry 0 reads as the default until it is written
  assign rk = rd_zero_r ? '0 : rd_key_r;
  assign rv = rd_zero_r ? default_r : rd_val_r;

  assign ins1_c = (p_r == '0) || (vp_r != req_r.new_value);
  assign ins2_c = (vq_r != req_r.new_value);
  assign dst_c  = NW'(p_r) + NW'(ins1_c) + NW'(ins2_c);
  assign n_c    = dst_c + NW'(cnt_r) - NW'(q_r);

  assign sts.empty     = (req_r.range_start >= req_r.range_end);
  assign sts.full      = (n_c > NW'(rvt_pkg::TABLE_DEPTH));
  assign sts.no_move   = (cnt_r == q_r) || (dst_c == NW'(q_r));
  assign sts.lookup    = (req_r.operation == rvt_pkg::OP_LOOKUP);
  assign sts.scan_last = (idx_r == cnt_r - CW'(1));
  assign sts.move_last = (mleft_r == CW'(1));
  assign sts.out_busy  = out_valid_r && !out_ready;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = mv_dst_r;
    wr_key  = rk;
    wr_val  = rv;
    if (mv_v_r) begin
      wr_en = 1'b1;
    end else if (cmd.ins1 && ins1_r) begin
      wr_en   = 1'b1;
      wr_addr = p_r[AW-1:0];
      wr_key  = req_r.range_start;
      wr_val  = req_r.new_value;
    end else if (cmd.ins2 && ins2_r) begin
      wr_en   = 1'b1;
      wr_addr = p_r[AW-1:0] + AW'(ins1_r);
      wr_key  = req_r.range_end;
      wr_val  = vq_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr] <= wr_key;
      val_mem[wr_addr] <= wr_val;
    end
    rd_key_r <= key_mem[idx_r[AW-1:0]];
    rd_val_r <= val_mem[idx_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= CW'(1);
      e0_valid_r  <= 1'b0;
      default_r   <= '0;
      sv_r        <= 1'b0;
      mv_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      rd_zero_r   <= 1'b1;
    end else begin
      rd_zero_r <= (idx_r[AW-1:0] == '0) && !e0_valid_r;
      if (cfg_we) begin
        default_r  <= cfg_data[VW-1:0];
        cnt_r      <= CW'(1);
        e0_valid_r <= 1'b0;
      end else begin
        if (wr_en && wr_addr == '0) e0_valid_r <= 1'b1;
        if (cmd.commit) cnt_r <= n_r;
      end
      sv_r   <= cmd.scan;
      mv_v_r <= cmd.shift;
      if (cmd.out_set) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_req;
      idx_r <= '0;
      p_r   <= '0;
      q_r   <= '0;
    end else if (cmd.scan) begin
      idx_r <= idx_r + CW'(1);
      sj_r  <= idx_r;
    end else if (cmd.calc) begin
      ins1_r  <= ins1_c;
      ins2_r  <= ins2_c;
      n_r     <= n_c[CW-1:0];
      up_r    <= dst_c > NW'(q_r);
      off_r   <= dst_c[AW-1:0] - q_r[AW-1:0];
      mleft_r <= cnt_r - q_r;
      idx_r   <= (dst_c > NW'(q_r)) ? cnt_r - CW'(1) : q_r;
    end else if (cmd.shift) begin
      idx_r    <= up_r ? idx_r - CW'(1) : idx_r + CW'(1);
      mleft_r  <= mleft_r - CW'(1);
      mv_dst_r <= idx_r[AW-1:0] + off_r;
    end
    // returned scan entry, sorted so the last hit wins
    if (sv_r) begin
      if (rk <= req_r.lookup_key) res_r <= rv;
      if (rk < req_r.range_start) begin
        p_r  <= sj_r + CW'(1);
        vp_r <= rv;
      end
      if (rk <= req_r.range_end) begin
        q_r  <= sj_r + CW'(1);
        vq_r <= rv;
      end
    end
    if (cmd.out_set) begin
      out_r.status     <= cmd.out_status;
      out_r.read_value <= (req_r.operation == rvt_pkg::OP_LOOKUP) ? 8'(res_r) : 8'd0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_r;

endmodule

// ===== rtl/range_value_table_unit.sv =====
// range value table: a sorted breakpoint table mapping every key to a value.
// one request at a time. a lookup scans the live entries. an assign scans,
// then moves the entries above the range one per cycle through the single
// table memory port, then writes up to two new breakpoints. a finished
// result sits in an output register so the next request can be taken while
// it waits. writing cfg_data resets the table to the one entry at key 0.
module range_value_table_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rvt_pkg::in_req_t   in_req,
  output logic               out_valid,
  input  logic               out_ready,
  output rvt_pkg::out_rsp_t  out_rsp,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_data
);

  // command and status between sequencer and datapath
  rvt_pkg::cmd_t cmd;
  rvt_pkg::sts_t sts;

  rvt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // table memory, scan results and output register
  rvt_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_rsp   (out_rsp)
  );

endmodule

// ===== rtl/rvt_checker.sv =====
module rvt_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input rvt_pkg::out_rsp_t out_rsp,
  input logic              out_valid,
  input logic              out_ready
);

  // one request in flight at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while busy");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_rsp.status != 2'd3)
    else $error("bad status code");

  // empty and full only come from assigns, which return zero
  a_assign_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_rsp.status == rvt_pkg::STATUS_EMPTY ||
                  out_rsp.status == rvt_pkg::STATUS_FULL) |-> out_rsp.read_value == 8'd0)
    else $error("assign result carries a value");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_rsp))
    else $error("result dropped or changed while stalled");

endmodule

bind range_value_table_unit rvt_checker u_rvt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_rsp   (out_rsp),
  .out_valid (out_valid),
  .out_ready (out_ready)
);

// ===== dv/range_value_table_checker.sv =====
module range_value_table_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  rvt_pkg::in_req_t  in_req,
  input  logic              out_valid,
  input  logic              out_ready,
  input  rvt_pkg::out_rsp_t out_rsp,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_data,
  output int                fail_count,
  output int                pending_count,
  output int                full_seen,
  output int                merge_seen
);

  logic [rvt_pkg::KEY_WIDTH-1:0]   bp_key [rvt_pkg::TABLE_DEPTH];
  logic [rvt_pkg::VALUE_WIDTH-1:0] bp_val [rvt_pkg::TABLE_DEPTH];
  int                              bp_count;
  logic [7:0]                      dflt;
  rvt_pkg::out_rsp_t               rsp_q[$];

  function automatic logic [rvt_pkg::VALUE_WIDTH-1:0] value_at_key(
      logic [rvt_pkg::KEY_WIDTH-1:0] k);
    for (int i = bp_count - 1; i >= 1; i--)
      if (bp_key[i] <= k) return bp_val[i];
    return bp_val[0];
  endfunction

  // rebuild the table around the new range; returns status
  function automatic logic [1:0] apply_range(logic [rvt_pkg::KEY_WIDTH-1:0] s,
                                             logic [rvt_pkg::KEY_WIDTH-1:0] e,
                                             logic [rvt_pkg::VALUE_WIDTH-1:0] v);
    logic [rvt_pkg::KEY_WIDTH-1:0]   nk [rvt_pkg::TABLE_DEPTH+2];
    logic [rvt_pkg::VALUE_WIDTH-1:0] nv [rvt_pkg::TABLE_DEPTH+2];
    logic [rvt_pkg::VALUE_WIDTH-1:0] ve;
    int n;
    int i;
    n = 0;
    i = 0;
    if (s >= e) return rvt_pkg::STATUS_EMPTY;
    ve = value_at_key(e);
    while (i < bp_count && bp_key[i] < s) begin
      nk[n] = bp_key[i]; nv[n] = bp_val[i]; n++; i++;
    end
    if (n == 0 || nv[n-1] != v) begin
      nk[n] = s; nv[n] = v; n++;
    end else merge_seen++;
    while (i < bp_count && bp_key[i] <= e) i++;
    if (ve != v) begin
      nk[n] = e; nv[n] = ve; n++;
    end else merge_seen++;
    while (i < bp_count && n < rvt_pkg::TABLE_DEPTH + 2) begin
      nk[n] = bp_key[i]; nv[n] = bp_val[i]; n++; i++;
    end
    if (n > rvt_pkg::TABLE_DEPTH) return rvt_pkg::STATUS_FULL;
    for (int j = 0; j < n; j++) begin
      bp_key[j] = nk[j]; bp_val[j] = nv[j];
    end
    bp_count = n;
    return rvt_pkg::STATUS_DONE;
  endfunction

  function automatic void clear_table();
    bp_key[0] = '0;
    bp_val[0] = dflt;
    bp_count = 1;
  endfunction

  always @(posedge clk) begin
    rvt_pkg::out_rsp_t exp_rsp;
    if (!rst_n) begin
      dflt = 8'd0;
      clear_table();
      rsp_q.delete();
      pending_count = 0;
      fail_count = 0;
      full_seen = 0;
      merge_seen = 0;
    end else begin
      if (cfg_we) begin
        dflt = cfg_data;
        clear_table();
      end
      if (out_valid && out_ready) begin
        if (rsp_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result value=%0d status=%0d", $time,
                   out_rsp.read_value, out_rsp.status);
        end else begin
          exp_rsp = rsp_q.pop_front();
          if (out_rsp.read_value !== exp_rsp.read_value) begin
            fail_count++;
            $display("%0t: read_value expected %0d actual %0d", $time,
                     exp_rsp.read_value, out_rsp.read_value);
          end
          if (out_rsp.status !== exp_rsp.status) begin
            fail_count++;
            $display("%0t: status expected %0d actual %0d", $time,
                     exp_rsp.status, out_rsp.status);
          end
        end
      end
      if (in_valid && in_ready) begin
        if (in_req.operation == rvt_pkg::OP_LOOKUP) begin
          exp_rsp.read_value = value_at_key(in_req.lookup_key);
          exp_rsp.status = rvt_pkg::STATUS_DONE;
        end else begin
          exp_rsp.read_value = 8'd0;
          exp_rsp.status = apply_range(in_req.range_start, in_req.range_end,
                                       in_req.new_value);
          if (exp_rsp.status == rvt_pkg::STATUS_FULL) full_seen++;
        end
        rsp_q.push_back(exp_rsp);
      end
      pending_count = rsp_q.size();
    end
  end
endmodule

// ===== dv/tb_range_value_table_unit.sv =====
module tb_range_value_table_unit;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  rvt_pkg::in_req_t  in_req = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  rvt_pkg::out_rsp_t out_rsp;
  logic              cfg_we = 1'b0;
  logic [7:0]        cfg_data = 8'd0;

  int fail_count;
  int pending_count;
  int full_seen;
  int merge_seen;
  int send_idle_pct;
  int recv_idle_pct;
  int cycle_count;
  int sent_count;

  // keys come from a small pool so ranges overlap and merge often
  logic [rvt_pkg::KEY_WIDTH-1:0] key_pool [16];

  always #5 clk = ~clk;

  range_value_table_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_rsp  (out_rsp),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  range_value_table_checker i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_req       (in_req),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_rsp      (out_rsp),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .pending_count(pending_count),
    .full_seen    (full_seen),
    .merge_seen   (merge_seen)
  );

  // receiver stall, redrawn each falling edge
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // watchdog: allows for full-table assigns under worst-case stalls
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > 1500000) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // one request, with random sender gaps first; waits for acceptance
  // valid stays up between requests unless a gap is drawn
  task automatic send_req(input rvt_pkg::in_req_t r);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    sent_count++;
  endtask

  task automatic send_assign(input logic [rvt_pkg::KEY_WIDTH-1:0] s,
                             input logic [rvt_pkg::KEY_WIDTH-1:0] e,
                             input logic [7:0] v);
    rvt_pkg::in_req_t r;
    r = '0;
    r.operation = rvt_pkg::OP_ASSIGN;
    r.range_start = s;
    r.range_end = e;
    r.new_value = v;
    r.lookup_key = $urandom;
    send_req(r);
  endtask

  task automatic send_lookup(input logic [rvt_pkg::KEY_WIDTH-1:0] k);
    rvt_pkg::in_req_t r;
    r = '0;
    r.operation = rvt_pkg::OP_LOOKUP;
    r.lookup_key = k;
    r.range_start = $urandom;
    r.range_end = $urandom;
    r.new_value = 8'($urandom);
    send_req(r);
  endtask

  // drain all expected results, then let the block settle before a config write
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic write_default(input logic [7:0] v);
    drain();
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  function automatic logic [rvt_pkg::KEY_WIDTH-1:0] pick_key();
    case ($urandom_range(9))
      0:       return $urandom;
      1:       return '1;
      2:       return '0;
      default: return key_pool[$urandom_range(15)];
    endcase
  endfunction

  task automatic random_items(input int count);
    logic [rvt_pkg::KEY_WIDTH-1:0] a;
    logic [rvt_pkg::KEY_WIDTH-1:0] b;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(2) == 0) begin
        send_lookup(pick_key());
      end else begin
        a = pick_key();
        b = pick_key();
        // mostly well-ordered ranges, some empty or reversed
        if ($urandom_range(9) != 0 && a > b) {a, b} = {b, a};
        send_assign(a, b, $urandom_range(3) == 0 ? 8'($urandom) : 8'($urandom_range(3)));
      end
    end
  endtask

  initial begin
    cycle_count = 0;
    sent_count = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < 16; i++) key_pool[i] = (i * 32'h1000_0000 / 16) + $urandom_range(3);
    key_pool[15] = 32'hFFFF_FFFE;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: extremes, empty and reversed ranges, merges, top key
    send_lookup('0);
    send_lookup('1);
    send_assign(32'd10, 32'd10, 8'hFF);
    send_assign(32'd20, 32'd10, 8'h11);
    send_assign('0, '1, 8'hFF);
    send_lookup('1);
    send_lookup(32'hFFFF_FFFE);
    send_assign(32'd100, 32'd200, 8'hFF);
    send_assign(32'd100, 32'd200, 8'h00);
    send_assign(32'd150, 32'd300, 8'h00);
    send_assign(32'd0, 32'd1, 8'h55);
    send_lookup(32'd0);
    send_lookup(32'd1);
    send_assign(32'd50, 32'd400, 8'hFF);
    send_assign(32'hAAAA_AAAA, 32'h5555_5555, 8'hAA);
    send_assign(32'h5555_5555, 32'hAAAA_AAAA, 8'h5A);
    send_lookup(32'h5555_5555);
    send_lookup(32'hAAAA_AAA9);
    send_lookup(32'hAAAA_AAAA);
    write_default(8'hFF);
    send_lookup(32'd1234);
    // fill the table until full is reported
    for (int i = 0; i < 34; i++) send_assign(i * 4 + 8, i * 4 + 10, i[0] ? 8'h01 : 8'h02);
    send_lookup(32'd9);

    // random phases, with the default register changed between phases
    send_idle_pct = 15; recv_idle_pct = 81;
    write_default(8'h00);
    random_items(165);
    // sender hold-off until everything has come back
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    send_idle_pct = 81; recv_idle_pct = 15;
    write_default(8'($urandom_range(1, 254)));
    random_items(165);
    send_idle_pct = 0; recv_idle_pct = 0;
    write_default(8'hFF);
    random_items(165);

    drain();
    $display("sent %0d requests across 4 default-value writes; %0d full rejects, %0d merges",
             sent_count, full_seen, merge_seen);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/rvt_pkg.sv
rtl/rvt_ctrl.sv
rtl/rvt_datapath.sv
rtl/range_value_table_unit.sv
rtl/rvt_checker.sv
dv/range_value_table_checker.sv
dv/tb_range_value_table_unit.sv
